[design/rtdc_pkg.sv]
// ----------------------------------------------------------------------------
// rtdc_pkg: shared types and widths for the RTD code to Celsius pipeline
// Fixed datapath widths, the divisor of the final scaling and the control
// word that travels with every request down the pipeline.
// ----------------------------------------------------------------------------
package rtdc_pkg;

	// Port widths
	localparam int CODE_W = 32;
	localparam int T_W    = 31;

	// Discriminant N = offset - slope * code, signed
	localparam int N_W = 62;

	// Non-negative N always fits in 60 bits
	localparam int RAD_W     = 60;
	localparam int SQRT_FRAC = 20;
	localparam int ROOT_W    = RAD_W / 2 + SQRT_FRAC;
	localparam int REM_W     = ROOT_W + 2;

	// Magnitude of 5 * (B - root) plus rounding half
	localparam int MAG_W = ROOT_W + 3;

	// Final scale: divide by 231 * 2^(SQRT_FRAC + DEN_SHIFT - FRAC_BITS)
	localparam int         DEN_SHIFT = 10;
	localparam logic [8:0] DIVISOR   = 9'd231;
	localparam int         DIV_STEPS = 8;

	// Control word carried beside the payload in every stage
	typedef struct packed {
		logic vld;  // stage holds a request
		logic bad;  // discriminant negative
		logic neg;  // numerator negative
	} ctl_t;

endpackage

[design/rtdc_front.sv]
// ----------------------------------------------------------------------------
// rtdc_front: discriminant of the inverse Callendar-Van Dusen equation
// Two stages: scale the code by the slope, then subtract from the offset.
// Flags a negative discriminant and hands the radicand to the root unit.
// ----------------------------------------------------------------------------
module rtdc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                code_vld,
	input  logic signed [rtdc_pkg::CODE_W-1:0]  code,
	output rtdc_pkg::ctl_t                      ctl_o,
	output logic        [rtdc_pkg::RAD_W-1:0]   rad_o
);
	import rtdc_pkg::*;

	localparam logic signed [29:0]    SLOPE  = 30'sd288750000;
	localparam logic signed [N_W-1:0] OFFSET = N_W'(64'sd1758480889 <<< 24);

	logic signed [N_W-1:0] prod;
	logic signed [N_W-1:0] prod_s1;
	logic signed [N_W-1:0] n_s2;
	logic                  vld_s1;
	logic                  vld_s2;

	// Slope times code, 30 by 32 bit signed product
	assign prod = SLOPE * code;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= code_vld;
			vld_s2 <= vld_s1;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			n_s2    <= OFFSET - prod_s1;
		end
	end

	// Drop the radicand to zero when the discriminant is negative
	assign ctl_o = '{vld: vld_s2, bad: n_s2[N_W-1], neg: 1'b0};
	assign rad_o = n_s2[N_W-1] ? '0 : n_s2[RAD_W-1:0];

`ifndef ASSERT_OFF
	a_rad_fits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !n_s2[N_W-1] |-> n_s2[N_W-2:RAD_W] == '0)
		else $error("radicand exceeds root unit width");
`endif

endmodule

[design/rtdc_sqrt.sv]
// ----------------------------------------------------------------------------
// rtdc_sqrt: pipelined square root
// One restoring digit per stage; the radicand is extended by SQRT_FRAC
// fractional pairs of zeros, giving floor(sqrt(N * 2^(2*SQRT_FRAC))).
// ----------------------------------------------------------------------------
module rtdc_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  rtdc_pkg::ctl_t                 ctl_i,
	input  logic [rtdc_pkg::RAD_W-1:0]     rad_i,
	output rtdc_pkg::ctl_t                 ctl_o,
	output logic [rtdc_pkg::ROOT_W-1:0]    root_o
);
	import rtdc_pkg::*;

	ctl_t              ctl_s  [0:ROOT_W-1];
	logic [RAD_W-1:0]  rad_s  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_s [0:ROOT_W-1];
	logic [REM_W-1:0]  rem_s  [0:ROOT_W-1];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		ctl_t              ctl_in;
		logic [RAD_W-1:0]  rad_in;
		logic [ROOT_W-1:0] root_in;
		logic [REM_W-1:0]  rem_in;
		logic [REM_W+1:0]  wrk;
		logic [REM_W+1:0]  trial;
		logic [REM_W+1:0]  dif;
		logic              ge;

		// Select the source of this stage
		if (k == 0) begin : g_first
			assign ctl_in  = ctl_i;
			assign rad_in  = rad_i;
			assign root_in = '0;
			assign rem_in  = '0;
		end else begin : g_next
			assign ctl_in  = ctl_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign root_in = root_s[k-1];
			assign rem_in  = rem_s[k-1];
		end

		// Bring down the next pair and try root*4 + 1
		assign wrk   = {rem_in, rad_in[RAD_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = (wrk >= trial);
		assign dif   = wrk - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? dif[REM_W-1:0] : wrk[REM_W-1:0];
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
				rad_s[k]  <= {rad_in[RAD_W-3:0], 2'b00};
			end
		end
	end

	assign ctl_o  = ctl_s[ROOT_W-1];
	assign root_o = root_s[ROOT_W-1];

`ifndef ASSERT_OFF
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[ROOT_W-1].vld |-> rem_s[ROOT_W-1] <= REM_W'({root_s[ROOT_W-1], 1'b0}))
		else $error("root remainder above twice the root");
`endif

endmodule

[design/rtdc_div231.sv]
// ----------------------------------------------------------------------------
// rtdc_div231: pipelined division by the constant 231
// Long division, DIV_STEPS quotient bits per stage with an 8-bit remainder.
// W must be a multiple of DIV_STEPS.
// ----------------------------------------------------------------------------
module rtdc_div231 #(
	parameter int W = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  rtdc_pkg::ctl_t   ctl_i,
	input  logic [W-1:0]     dvd_i,
	output rtdc_pkg::ctl_t   ctl_o,
	output logic [W-1:0]     quo_o
);
	import rtdc_pkg::*;

	localparam int NSTG = W / DIV_STEPS;

	ctl_t         ctl_s [0:NSTG-1];
	logic [W-1:0] dvd_s [0:NSTG-1];
	logic [W-1:0] quo_s [0:NSTG-1];
	logic [7:0]   rem_s [0:NSTG-1];

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		ctl_t         ctl_in;
		logic [W-1:0] dvd_in;
		logic [W-1:0] quo_in;
		logic [7:0]   rem_in;
		logic [W-1:0] dvd_nx;
		logic [W-1:0] quo_nx;
		logic [7:0]   rem_nx;

		// Select the source of this stage
		if (k == 0) begin : g_first
			assign ctl_in = ctl_i;
			assign dvd_in = dvd_i;
			assign quo_in = '0;
			assign rem_in = '0;
		end else begin : g_next
			assign ctl_in = ctl_s[k-1];
			assign dvd_in = dvd_s[k-1];
			assign quo_in = quo_s[k-1];
			assign rem_in = rem_s[k-1];
		end

		// Shift in dividend bits, subtract the divisor where it fits
		always_comb begin
			logic [8:0] part;
			dvd_nx = dvd_in;
			quo_nx = quo_in;
			rem_nx = rem_in;
			for (int j = 0; j < DIV_STEPS; j++) begin
				part   = {rem_nx, dvd_nx[W-1]};
				dvd_nx = {dvd_nx[W-2:0], 1'b0};
				if (part >= DIVISOR) begin
					rem_nx = 8'(part - DIVISOR);
					quo_nx = {quo_nx[W-2:0], 1'b1};
				end else begin
					rem_nx = part[7:0];
					quo_nx = {quo_nx[W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[k] <= dvd_nx;
				quo_s[k] <= quo_nx;
				rem_s[k] <= rem_nx;
			end
		end
	end

	assign ctl_o = ctl_s[NSTG-1];
	assign quo_o = quo_s[NSTG-1];

`ifndef ASSERT_OFF
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[NSTG-1].vld |-> {1'b0, rem_s[NSTG-1]} < DIVISOR)
		else $error("division remainder not below divisor");
`endif

endmodule

[design/rtd_code_to_celsius_unit.sv]
// ----------------------------------------------------------------------------
// rtd_code_to_celsius_unit: PT100 code to Celsius converter
// Inverse Callendar-Van Dusen solve of a controller code, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one signed code per clock while code_stall is low and returns one
// temperature per code, in order, in units of 2^-FRAC_BITS degrees C,
// saturated to 31 bits. A code whose discriminant is negative returns
// invalid = 1 with -273 C (saturated). The steps are the discriminant, the
// square root at one result bit per stage, scaling, the final divide by 231,
// and one output register. A stalled result holds the whole pipeline, so
// code_stall follows result_stall while a result is waiting.
// ----------------------------------------------------------------------------
module rtd_code_to_celsius_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                code_valid,
	output logic                                code_stall,
	input  logic signed [rtdc_pkg::CODE_W-1:0]  code,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [rtdc_pkg::T_W-1:0]     temperature,
	output logic                                invalid
);
	import rtdc_pkg::*;

	localparam int K     = SQRT_FRAC + DEN_SHIFT - FRAC_BITS;
	localparam int X_W   = MAG_W - K;
	localparam int DIV_W = ((X_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;

	localparam logic [ROOT_W-1:0] B_SCALED = ROOT_W'(64'd160083968) << SQRT_FRAC;
	localparam logic [MAG_W-1:0]  HALF     = MAG_W'(DIVISOR) << (K - 1);

	localparam logic signed [63:0]    INV_FULL = -64'sd273 * (64'sd1 <<< FRAC_BITS);
	localparam logic signed [63:0]    T_MIN_L  = -(64'sd1 <<< (T_W - 1));
	localparam logic signed [T_W-1:0] INV_T    =
		(INV_FULL < T_MIN_L) ? T_W'(T_MIN_L) : T_W'(INV_FULL);
	localparam logic [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
	localparam logic [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

	logic              en;
	ctl_t              ctl_f;
	logic [RAD_W-1:0]  rad_f;
	ctl_t              ctl_r;
	logic [ROOT_W-1:0] root_r;
	ctl_t              ctl_d;
	logic [DIV_W-1:0]  quo_d;

	ctl_t              ctl_s1;
	ctl_t              ctl_s2;
	ctl_t              ctl_s3;
	logic [ROOT_W:0]   diff_s1;
	logic [ROOT_W-1:0] mag_s2;
	logic [X_W-1:0]    x_s3;

	logic [ROOT_W:0]   diff_neg;
	logic [MAG_W-1:0]  sum;
	logic              sat;
	logic [T_W-1:0]    qext;
	logic [T_W-1:0]    temp_nx;

	logic              result_valid_q;
	logic [T_W-1:0]    temperature_q;
	logic              invalid_q;

	// Advance everything unless a finished result is held
	assign en         = !result_valid_q || !result_stall;
	assign code_stall = !en;

	rtdc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.code_vld (code_valid),
		.code     (code),
		.ctl_o    (ctl_f),
		.rad_o    (rad_f)
	);

	rtdc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl_f),
		.rad_i  (rad_f),
		.ctl_o  (ctl_r),
		.root_o (root_r)
	);

	// Take magnitude and sign of B - root, then scale by 5 and round
	assign diff_neg = ~diff_s1 + (ROOT_W+1)'(1);
	assign sum      = ({3'b000, mag_s2} << 2) + {3'b000, mag_s2} + HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_r;
			ctl_s2 <= '{vld: ctl_s1.vld, bad: ctl_s1.bad, neg: diff_s1[ROOT_W]};
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= {1'b0, B_SCALED} - {1'b0, root_r};
			mag_s2  <= diff_s1[ROOT_W] ? diff_neg[ROOT_W-1:0] : diff_s1[ROOT_W-1:0];
			x_s3    <= sum[MAG_W-1:K];
		end
	end

	rtdc_div231 #(
		.W (DIV_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl_s3),
		.dvd_i  (DIV_W'(x_s3)),
		.ctl_o  (ctl_d),
		.quo_o  (quo_d)
	);

	// Apply sign, saturate, and substitute the invalid value
	assign sat  = |quo_d[DIV_W-1:T_W-1];
	assign qext = {1'b0, quo_d[T_W-2:0]};

	always_comb begin
		if (ctl_d.bad) begin
			temp_nx = INV_T;
		end else if (ctl_d.neg) begin
			temp_nx = sat ? T_MIN : (~qext + T_W'(1));
		end else begin
			temp_nx = sat ? T_MAX : qext;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= ctl_d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temperature_q <= temp_nx;
			invalid_q     <= ctl_d.bad;
		end
	end

	assign result_valid = result_valid_q;
	assign temperature  = temperature_q;
	assign invalid      = invalid_q;

`ifndef ASSERT_OFF
	a_invalid_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && invalid |-> temperature == INV_T)
		else $error("invalid result without the fixed temperature");
`endif

endmodule
